// ----- rtl/sdpg_pkg.sv -----
// Shared types and constants for the scope display pixel generator.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package sdpg_pkg;

  // field widths
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned COLOUR_W = 16;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_AW   = 6;
  localparam int unsigned REG_IDX_W = 3;

  // register indexes, 8 bytes apart on the configuration bus
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TRACE_COLOURS  = 3'd0,
    REG_CURSOR_COLOURS = 3'd1,
    REG_GRID_COLOURS   = 3'd2,
    REG_CURSOR_ENABLE  = 3'd3,
    REG_X_CURSORS      = 3'd4,
    REG_Y_CURSORS      = 3'd5,
    REG_TRACE1_OFFSET  = 3'd6
  } reg_idx_t;

  // reset values of the registers
  localparam logic [31:0] TRACE_COLOURS_RST  = 32'hFFE0_07FF;
  localparam logic [63:0] CURSOR_COLOURS_RST = 64'hFFFF_FFFF_07E0_07E0;
  localparam logic [31:0] GRID_COLOURS_RST   = 32'h8410_0000;
  localparam logic        CURSOR_ENABLE_RST  = 1'b1;
  localparam logic [15:0] X_CURSORS_RST      = 16'hF122;
  localparam logic [15:0] Y_CURSORS_RST      = 16'hED36;
  localparam logic [7:0]  TRACE1_OFFSET_RST  = 8'd22;

  // register file contents as seen by the colour logic
  typedef struct packed {
    logic [31:0]       trace_colours;
    logic [63:0]       cursor_colours;
    logic [31:0]       grid_colours;
    logic              cursor_enable;
    logic [15:0]       x_cursors;
    logic [15:0]       y_cursors;
    logic signed [7:0] trace1_offset;
  } cfg_t;

  // one pixel request
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] trace1_now;
    logic [COORD_W-1:0] trace1_next;
    logic [COORD_W-1:0] trace2_now;
    logic [COORD_W-1:0] trace2_next;
  } pix_req_t;

endpackage

`default_nettype wire

// ----- rtl/sdpg_if.sv -----
// Valid/ready channel interfaces: pixel request in, pixel colour out.
// Depends on sdpg_pkg for the field widths.
`default_nettype none

interface sdpg_req_if
  import sdpg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] trace1_now;
  logic [COORD_W-1:0] trace1_next;
  logic [COORD_W-1:0] trace2_now;
  logic [COORD_W-1:0] trace2_next;

  modport source (
    output valid, column, row, trace1_now, trace1_next, trace2_now, trace2_next,
    input  ready
  );
  modport sink (
    input  valid, column, row, trace1_now, trace1_next, trace2_now, trace2_next,
    output ready
  );
endinterface

interface sdpg_pix_if
  import sdpg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] pixel_colour;

  modport source (output valid, pixel_colour, input ready);
  modport sink (input valid, pixel_colour, output ready);
endinterface

`default_nettype wire

// ----- rtl/sdpg_cfg.sv -----
// APB-style configuration register file for the pixel generator.
// Depends on sdpg_pkg for the register map and the cfg_t struct.
`default_nettype none

module sdpg_cfg
  import sdpg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TRACE_COLOURS:  cfg_nxt.trace_colours  = pwdata[31:0];
        REG_CURSOR_COLOURS: cfg_nxt.cursor_colours = pwdata;
        REG_GRID_COLOURS:   cfg_nxt.grid_colours   = pwdata[31:0];
        REG_CURSOR_ENABLE:  cfg_nxt.cursor_enable  = pwdata[0];
        REG_X_CURSORS:      cfg_nxt.x_cursors      = pwdata[15:0];
        REG_Y_CURSORS:      cfg_nxt.y_cursors      = pwdata[15:0];
        REG_TRACE1_OFFSET:  cfg_nxt.trace1_offset  = $signed(pwdata[7:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trace_colours  <= TRACE_COLOURS_RST;
      cfg_r.cursor_colours <= CURSOR_COLOURS_RST;
      cfg_r.grid_colours   <= GRID_COLOURS_RST;
      cfg_r.cursor_enable  <= CURSOR_ENABLE_RST;
      cfg_r.x_cursors      <= X_CURSORS_RST;
      cfg_r.y_cursors      <= Y_CURSORS_RST;
      cfg_r.trace1_offset  <= TRACE1_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read-back mux
  always_comb begin
    unique case (idx)
      REG_TRACE_COLOURS:  prdata = {32'd0, cfg_r.trace_colours};
      REG_CURSOR_COLOURS: prdata = cfg_r.cursor_colours;
      REG_GRID_COLOURS:   prdata = {32'd0, cfg_r.grid_colours};
      REG_CURSOR_ENABLE:  prdata = {63'd0, cfg_r.cursor_enable};
      REG_X_CURSORS:      prdata = {48'd0, cfg_r.x_cursors};
      REG_Y_CURSORS:      prdata = {48'd0, cfg_r.y_cursors};
      REG_TRACE1_OFFSET:  prdata = {56'd0, cfg_r.trace1_offset};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sdpg_shade.sv -----
// Colour logic for one pixel: grid pattern, cursors and the two trace spans.
// Depends on sdpg_pkg for pix_req_t and cfg_t.
`default_nettype none

module sdpg_shade
  import sdpg_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256,
  parameter int unsigned MAJOR_STEP    = 32
) (
  input  pix_req_t            req,
  input  cfg_t                cfg,
  output logic [COLOUR_W-1:0] colour
);

  // marks every coordinate that is a multiple of step, built by counting
  function automatic logic [255:0] step_mask(input int unsigned step);
    logic [255:0] m;
    int unsigned  k;
    m = '0;
    k = 0;
    for (int i = 0; i < 256; i++) begin
      m[i] = (k == 0);
      k = (k + 1 == step) ? 0 : k + 1;
    end
    return m;
  endfunction

  localparam logic [255:0] MAJOR_MASK = step_mask(MAJOR_STEP);

  localparam logic [7:0] COL_MID_LO = 8'(SCREEN_WIDTH / 2 - 1);
  localparam logic [7:0] COL_MID_HI = 8'(SCREEN_WIDTH / 2 + 1);
  localparam logic [7:0] COL_EDGE   = 8'(SCREEN_WIDTH - 2);
  localparam logic [7:0] COL_LAST   = 8'(SCREEN_WIDTH - 1);
  localparam logic [7:0] ROW_MID_LO = 8'(SCREEN_HEIGHT / 2 - 1);
  localparam logic [7:0] ROW_MID_HI = 8'(SCREEN_HEIGHT / 2 + 1);
  localparam logic [7:0] ROW_EDGE   = 8'(SCREEN_HEIGHT - 2);
  localparam logic [8:0] ROW_LIMIT  = 9'(SCREEN_HEIGHT);

  logic [7:0]          x, y, xa, xb, ya, yb;
  logic [COLOUR_W-1:0] grat, back, base, cur_col;
  logic                tick_col, tick_row, x_major, y_major, last;
  logic signed [9:0]   off, t1a, t1b, y_s, t1_lo, t1_hi;
  logic                t1_hit, t2_hit;
  logic [7:0]          t2b, t2_lo, t2_hi;

  assign x    = req.column;
  assign y    = req.row;
  assign xa   = cfg.x_cursors[7:0];
  assign xb   = cfg.x_cursors[15:8];
  assign ya   = cfg.y_cursors[7:0];
  assign yb   = cfg.y_cursors[15:8];
  assign grat = cfg.grid_colours[31:16];
  assign back = cfg.grid_colours[15:0];
  assign last = (x >= COL_LAST);

  assign x_major  = MAJOR_MASK[x];
  assign y_major  = MAJOR_MASK[y];
  assign tick_col = (x == 8'd1) || (x == COL_MID_HI) || (x == COL_MID_LO) || (x == COL_EDGE);
  assign tick_row = (y == 8'd1) || (y == ROW_MID_HI) || (y == ROW_MID_LO) || (y == ROW_EDGE);

  // layered base pattern
  always_comb begin
    if (cfg.cursor_enable && x == xa) begin
      base = !y[0] ? cfg.cursor_colours[63:48] : back;
    end else if (cfg.cursor_enable && x == xb) begin
      base = !y[0] ? cfg.cursor_colours[47:32] : back;
    end else if (tick_col) begin
      base = (y[2:0] == 3'd0) ? grat : back;
    end else if (x_major) begin
      base = grat;
    end else if (x[2:0] == 3'd0) begin
      base = (tick_row || y_major) ? grat : back;
    end else begin
      base = y_major ? grat : back;
    end
  end

  // y cursor rows on even columns, b over a
  always_comb begin
    cur_col = base;
    if (cfg.cursor_enable && !x[0]) begin
      if (y == ya) cur_col = cfg.cursor_colours[31:16];
      if (y == yb) cur_col = cfg.cursor_colours[15:0];
    end
  end

  // trace one span with signed offset, both ends must be in rows 1 to SCREEN_HEIGHT-1
  assign off   = {{2{cfg.trace1_offset[7]}}, cfg.trace1_offset};
  assign t1a   = $signed({2'b00, req.trace1_now}) + off;
  assign t1b   = last ? t1a : ($signed({2'b00, req.trace1_next}) + off);
  assign y_s   = $signed({2'b00, y});
  assign t1_lo = (t1a < t1b) ? t1a : t1b;
  assign t1_hi = (t1a < t1b) ? t1b : t1a;
  assign t1_hit = (t1a > 10'sd0) && (t1a < $signed({1'b0, ROW_LIMIT}))
               && (t1b > 10'sd0) && (t1b < $signed({1'b0, ROW_LIMIT}))
               && (y_s >= t1_lo) && (y_s <= t1_hi);

  // trace two span, only the start is range checked
  assign t2b    = last ? req.trace2_now : req.trace2_next;
  assign t2_lo  = (req.trace2_now < t2b) ? req.trace2_now : t2b;
  assign t2_hi  = (req.trace2_now < t2b) ? t2b : req.trace2_now;
  assign t2_hit = (req.trace2_now != 8'd0) && ({1'b0, req.trace2_now} < ROW_LIMIT)
               && (y >= t2_lo) && (y <= t2_hi);

  // trace two wins over trace one
  always_comb begin
    if (t2_hit) begin
      colour = cfg.trace_colours[15:0];
    end else if (t1_hit) begin
      colour = cfg.trace_colours[31:16];
    end else begin
      colour = cur_col;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scope_display_pixel_generator.sv -----
// Scope display pixel generator: maps a pixel request to its RGB565 colour.
//
// Channels: in_chan carries pixel requests (column, row and both traces'
// samples at this column and the next); out_chan returns one pixel_colour
// per request, in request order. Both use valid/ready, and a transfer takes
// place on a rising edge where valid and ready are both high.
// Configuration: APB-style port, 64-bit data, registers 8 bytes apart;
// writes complete in the access cycle, pready is tied high.
// Path: an accepted request is held in the input register, and its colour is
// registered in the result register before it is shown on out_chan.
// Throughput: one pixel per clock while out_chan.ready is high; the colour logic
// sits in a single stage between the two registers.
// Stall: when the receiver holds ready low, the result register holds and
// one further request may wait in the input register; in_chan.ready drops
// only once both are full.
// Reset: rst_n is synchronous and active low; it empties both stages and
// restores the configuration registers to their reset values; payload registers are not reset.
// Depends on sdpg_pkg, sdpg_if, sdpg_cfg and sdpg_shade.
`default_nettype none

module scope_display_pixel_generator
  import sdpg_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256,
  parameter int unsigned MAJOR_STEP    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sdpg_req_if.sink               in_chan,
  sdpg_pix_if.source             out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t                cfg;
  pix_req_t            in_req, s1_req_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COLOUR_W-1:0] out_colour_r, colour;
  logic                in_take, s1_move;

  sdpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdpg_shade #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAJOR_STEP    (MAJOR_STEP)
  ) u_shade (
    .req    (s1_req_r),
    .cfg    (cfg),
    .colour (colour)
  );

  // request payload into one struct
  always_comb begin
    in_req.column      = in_chan.column;
    in_req.row         = in_chan.row;
    in_req.trace1_now  = in_chan.trace1_now;
    in_req.trace1_next = in_chan.trace1_next;
    in_req.trace2_now  = in_chan.trace2_now;
    in_req.trace2_next = in_chan.trace2_next;
  end

  // handshake flow between the two stages
  assign s1_move         = !out_valid_r || out_chan.ready;
  assign in_chan.ready   = !s1_valid_r || s1_move;
  assign in_take         = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.pixel_colour = out_colour_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_req;
    end
    if (s1_move && s1_valid_r) begin
      out_colour_r <= colour;
    end
  end

endmodule

`default_nettype wire
